@@ rtl/sfa_pkg.sv @@
// shared constants, types and coefficient tables for the stft frame analyzer
package sfa_pkg;

    localparam int FRAME_LENGTH = 64;
    localparam int NUM_BINS     = FRAME_LENGTH / 2 + 1;
    localparam int AW           = $clog2(FRAME_LENGTH);
    localparam int CW           = $clog2(FRAME_LENGTH + 1);
    localparam int SAMPLE_W     = 16;
    localparam int HOP_W        = 7;
    localparam int FRAME_W      = 16;
    localparam int BIN_W        = 6;
    localparam int OUT_W        = 24;
    localparam int WIN_W        = 17;
    localparam int TW_W         = 17;
    localparam int XW_W         = SAMPLE_W + WIN_W + 1;
    localparam int PROD_W       = XW_W + TW_W;
    localparam int ACC_W        = PROD_W + AW + 1;
    localparam int HOP_RESET    = 16;

    localparam longint Q30_ONE     = 64'sd1 << 30;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef longint div_tab_t [10];
    localparam div_tab_t HS_DIV = '{1, 6, 20, 42, 72, 110, 156, 210, 272, 342};
    localparam div_tab_t HC_DIV = '{1, 2, 12, 30, 56, 90, 132, 182, 240, 306};

    typedef logic [WIN_W-1:0]        win_tab_t [FRAME_LENGTH];
    typedef logic signed [TW_W-1:0]  tw_tab_t  [FRAME_LENGTH];

    typedef struct packed {
        longint c;
        longint s;
    } cs_t;

    typedef struct packed {
        logic                wr_en;
        logic [AW-1:0]       wr_addr;
        logic [SAMPLE_W-1:0] wr_data;
        logic                iss_valid;
        logic [AW-1:0]       rd_addr;
        logic                entry_valid;
        logic [AW-1:0]       n;
        logic [AW-1:0]       tw;
        logic                first;
        logic                last;
        logic                load;
        logic [FRAME_W-1:0]  frame_num;
        logic [BIN_W-1:0]    k;
        logic                last_bin;
    } cmd_t;

    typedef struct packed {
        logic acc_done;
        logic out_free;
    } status_t;

    function automatic longint mul_q30(longint a, longint b);
        return (a * b) / Q30_ONE;
    endfunction

    function automatic cs_t trig_q30(int m, bit use_win);
        longint t, quad, rem, a, x2, hs, hc;
        cs_t r;
        if (use_win) begin
            t    = longint'(m % (FRAME_LENGTH - 1)) * 4;
            quad = t / (FRAME_LENGTH - 1);
            rem  = t - quad * (FRAME_LENGTH - 1);
            a    = (rem * HALF_PI_Q30 + (FRAME_LENGTH - 1) / 2) / (FRAME_LENGTH - 1);
        end else begin
            t    = longint'(m % FRAME_LENGTH) * 4;
            quad = t / FRAME_LENGTH;
            rem  = t - quad * FRAME_LENGTH;
            a    = (rem * HALF_PI_Q30 + FRAME_LENGTH / 2) / FRAME_LENGTH;
        end
        x2 = mul_q30(a, a);
        hs = Q30_ONE;
        hc = Q30_ONE;
        for (int k = 9; k >= 1; k--) begin
            hs = Q30_ONE - mul_q30(x2, hs) / HS_DIV[k];
            hc = Q30_ONE - mul_q30(x2, hc) / HC_DIV[k];
        end
        hs = mul_q30(a, hs);
        case (quad & 3)
            0:       begin r.c = hc;  r.s = hs;  end
            1:       begin r.c = -hs; r.s = hc;  end
            2:       begin r.c = -hc; r.s = -hs; end
            default: begin r.c = hs;  r.s = -hc; end
        endcase
        return r;
    endfunction

    function automatic win_tab_t build_win();
        win_tab_t tab;
        cs_t cs;
        longint h;
        for (int n = 0; n < FRAME_LENGTH; n++) begin
            cs = trig_q30(n, 1'b1);
            h  = (Q30_ONE - cs.c) / 2;
            if (h < 0) h = 0;
            if (h > Q30_ONE) h = Q30_ONE;
            tab[n] = WIN_W'((h + (64'sd1 << 14)) >>> 15);
        end
        return tab;
    endfunction

    function automatic tw_tab_t build_cos();
        tw_tab_t tab;
        cs_t cs;
        for (int n = 0; n < FRAME_LENGTH; n++) begin
            cs     = trig_q30(n, 1'b0);
            tab[n] = TW_W'((cs.c + (64'sd1 << 14)) >>> 15);
        end
        return tab;
    endfunction

    function automatic tw_tab_t build_sin();
        tw_tab_t tab;
        cs_t cs;
        for (int n = 0; n < FRAME_LENGTH; n++) begin
            cs     = trig_q30(n, 1'b0);
            tab[n] = TW_W'((cs.s + (64'sd1 << 14)) >>> 15);
        end
        return tab;
    endfunction

    localparam win_tab_t WIN_TAB = build_win();
    localparam tw_tab_t  COS_TAB = build_cos();
    localparam tw_tab_t  SIN_TAB = build_sin();

endpackage

@@ rtl/sfa_ram.sv @@
// generic single-write, single-read ram with registered read
module sfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/sfa_datapath.sv @@
// sample history, windowed multiply-accumulate pipeline and output register
module sfa_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sfa_pkg::cmd_t                cmd,
    output sfa_pkg::status_t             status,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [71:0]                  m_tdata,
    output logic                         m_tlast
);
    import sfa_pkg::*;

    logic [SAMPLE_W-1:0] rd_data;

    logic                     v1_reg, ev1_reg, first1_reg, last1_reg;
    logic [WIN_W-1:0]         win1_reg;
    logic signed [TW_W-1:0]   cos1_reg, sin1_reg;
    logic                     v2_reg, first2_reg, last2_reg;
    logic signed [XW_W-1:0]   xw2_reg;
    logic signed [TW_W-1:0]   cos2_reg, sin2_reg;
    logic                     v3_reg, first3_reg, last3_reg;
    logic signed [PROD_W-1:0] pre3_reg, pim3_reg;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_im_reg;
    logic                     done_reg;

    logic signed [SAMPLE_W-1:0] samp1;
    logic signed [XW_W-1:0]     xw1;
    logic signed [ACC_W-1:0]    re_base, im_base;

    logic                    m_valid_reg;
    logic [FRAME_W-1:0]      frame_out_reg;
    logic [BIN_W-1:0]        bin_out_reg;
    logic [OUT_W-1:0]        re_out_reg, im_out_reg;
    logic                    last_out_reg;

    logic [OUT_W-1:0] re_sat, im_sat;

    sfa_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(FRAME_LENGTH)
    ) u_hist (
        .aclk (aclk),
        .we   (cmd.wr_en),
        .waddr(cmd.wr_addr),
        .wdata(cmd.wr_data),
        .raddr(cmd.rd_addr),
        .rdata(rd_data)
    );

    function automatic logic [OUT_W-1:0] round_sat(logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-31:0] q;
        t = v + (ACC_W'(1) <<< 29);
        q = (ACC_W-30)'(t >>> 30);
        if (q > (ACC_W-30)'(8388607)) begin
            return OUT_W'(24'h7fffff);
        end else if (q < -(ACC_W-30)'(8388608)) begin
            return OUT_W'(24'h800000);
        end
        return q[OUT_W-1:0];
    endfunction

    assign samp1 = ev1_reg ? $signed(rd_data) : '0;
    assign xw1   = XW_W'(samp1) * XW_W'($signed({1'b0, win1_reg}));

    assign re_base = first3_reg ? '0 : acc_re_reg;
    assign im_base = first3_reg ? '0 : acc_im_reg;

    assign re_sat = round_sat(acc_re_reg);
    assign im_sat = round_sat(acc_im_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.iss_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.load) begin
                done_reg <= 1'b0;
            end else if (v3_reg && last3_reg) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ev1_reg    <= cmd.entry_valid;
        first1_reg <= cmd.first;
        last1_reg  <= cmd.last;
        win1_reg   <= WIN_TAB[cmd.n];
        cos1_reg   <= COS_TAB[cmd.tw];
        sin1_reg   <= SIN_TAB[cmd.tw];

        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        xw2_reg    <= xw1;
        cos2_reg   <= cos1_reg;
        sin2_reg   <= sin1_reg;

        first3_reg <= first2_reg;
        last3_reg  <= last2_reg;
        pre3_reg   <= PROD_W'(xw2_reg) * PROD_W'(cos2_reg);
        pim3_reg   <= PROD_W'(xw2_reg) * PROD_W'(sin2_reg);

        if (v3_reg) begin
            acc_re_reg <= re_base + ACC_W'(pre3_reg);
            acc_im_reg <= im_base - ACC_W'(pim3_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            frame_out_reg <= cmd.frame_num;
            bin_out_reg   <= cmd.k;
            re_out_reg    <= re_sat;
            im_out_reg    <= im_sat;
            last_out_reg  <= cmd.last_bin;
        end
    end

    assign status = '{acc_done: done_reg, out_free: (!m_valid_reg || m_tready)};

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = last_out_reg;
    assign m_tdata  = {2'b00, im_out_reg, re_out_reg, bin_out_reg, frame_out_reg};
endmodule

@@ rtl/sfa_ctrl.sv @@
// stream counters, hop register and frame sequencer
module sfa_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sfa_pkg::SAMPLE_W-1:0]    sample,
    input  logic                            restart,
    input  logic                            cfg_wr_en,
    input  logic [sfa_pkg::HOP_W-1:0]       cfg_wr_data,
    input  sfa_pkg::status_t                status,
    output sfa_pkg::cmd_t                   cmd
);
    import sfa_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_LOAD  = 2'd3;

    localparam logic [CW-1:0] L_C    = CW'(FRAME_LENGTH);
    localparam logic [CW-1:0] HALF_C = CW'(FRAME_LENGTH / 2);
    localparam logic [AW-1:0] LAST_N = AW'(FRAME_LENGTH - 1);
    localparam logic [AW-1:0] LAST_K = AW'(FRAME_LENGTH / 2);

    logic [1:0]         state_reg, state_next;
    logic [HOP_W-1:0]   hop_reg;
    logic [AW-1:0]      wptr_reg, wptr_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [CW-1:0]      pad_reg, pad_next;
    logic [HOP_W-1:0]   phase_reg, phase_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [AW-1:0]      base_reg, base_next;
    logic [AW-1:0]      n_reg, n_next;
    logic [AW-1:0]      k_reg, k_next;
    logic [AW-1:0]      tw_reg, tw_next;

    logic               accept;
    logic               take;
    logic [CW-1:0]      fill_cur, pad_cur;
    logic [HOP_W-1:0]   phase_cur;
    logic [FRAME_W-1:0] frame_cur;
    logic [HOP_W-1:0]   hop_eff;
    logic [HOP_W:0]     phase_inc;
    logic [AW:0]        addr_sum, tw_sum;
    logic [CW:0]        valid_sum;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign fill_cur  = restart ? '0 : fill_reg;
    assign pad_cur   = restart ? HALF_C : pad_reg;
    assign phase_cur = restart ? '0 : phase_reg;
    assign frame_cur = restart ? '0 : frame_reg;
    assign hop_eff   = (hop_reg == '0) ? HOP_W'(1) : hop_reg;
    assign phase_inc = {1'b0, phase_cur} + 1'b1;

    assign addr_sum  = {1'b0, base_reg} + {1'b0, n_reg};
    assign tw_sum    = {1'b0, tw_reg} + {1'b0, k_reg};
    assign valid_sum = {2'b00, n_reg} + {1'b0, fill_reg};

    always_comb begin
        fill_next  = fill_reg;
        pad_next   = pad_reg;
        phase_next = phase_reg;
        frame_next = frame_reg;
        wptr_next  = wptr_reg;
        base_next  = base_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        tw_next    = tw_reg;
        state_next = state_reg;
        take       = 1'b0;

        cmd             = '0;
        cmd.wr_addr     = wptr_reg;
        cmd.wr_data     = sample;
        cmd.rd_addr     = (addr_sum >= (AW+1)'(FRAME_LENGTH)) ?
                          AW'(addr_sum - (AW+1)'(FRAME_LENGTH)) : addr_sum[AW-1:0];
        cmd.entry_valid = (valid_sum >= {1'b0, L_C});
        cmd.n           = n_reg;
        cmd.tw          = tw_reg;
        cmd.first       = (n_reg == '0);
        cmd.last        = (n_reg == LAST_N);
        cmd.frame_num   = frame_reg;
        cmd.k           = BIN_W'(k_reg);
        cmd.last_bin    = (k_reg == LAST_K);

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.wr_en  = 1'b1;
                    wptr_next  = (wptr_reg == LAST_N) ? '0 : wptr_reg + 1'b1;
                    fill_next  = (fill_cur < L_C) ? fill_cur + 1'b1 : fill_cur;
                    frame_next = frame_cur;
                    if (pad_cur < L_C) begin
                        pad_next   = pad_cur + 1'b1;
                        take       = (pad_next == L_C);
                        phase_next = take ? '0 : phase_cur;
                    end else begin
                        pad_next   = pad_cur;
                        take       = (phase_inc >= {1'b0, hop_eff});
                        phase_next = take ? '0 : phase_inc[HOP_W-1:0];
                    end
                    if (take) begin
                        base_next  = wptr_next;
                        n_next     = '0;
                        k_next     = '0;
                        tw_next    = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                cmd.iss_valid = 1'b1;
                n_next  = n_reg + 1'b1;
                tw_next = (tw_sum >= (AW+1)'(FRAME_LENGTH)) ?
                          AW'(tw_sum - (AW+1)'(FRAME_LENGTH)) : tw_sum[AW-1:0];
                if (n_reg == LAST_N) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (status.acc_done) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (status.out_free) begin
                    cmd.load = 1'b1;
                    n_next   = '0;
                    tw_next  = '0;
                    if (k_reg == LAST_K) begin
                        frame_next = frame_reg + 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            hop_reg   <= HOP_W'(HOP_RESET);
            wptr_reg  <= '0;
            fill_reg  <= '0;
            pad_reg   <= HALF_C;
            phase_reg <= '0;
            frame_reg <= '0;
            base_reg  <= '0;
            n_reg     <= '0;
            k_reg     <= '0;
            tw_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                hop_reg <= cfg_wr_data;
            end
            wptr_reg  <= wptr_next;
            fill_reg  <= fill_next;
            pad_reg   <= pad_next;
            phase_reg <= phase_next;
            frame_reg <= frame_next;
            base_reg  <= base_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            tw_reg    <= tw_next;
        end
    end
endmodule

@@ rtl/stft_frame_analyzer_core.sv @@
// top level of the streaming hann-windowed stft frame analyzer
// A sample that completes no frame leaves the core idle and ready. A sample that
// completes a frame starts 33 bins of 64 windowed products each, computed
// one product pair per cycle in a single shared multiply-accumulate pipeline
// fed from the history ram; each bin issues its 64 products, flushes the
// pipeline and is loaded, and the frame holds the input until its last bin is
// loaded, which waits while m_tready is held low and a finished bin cannot
// be loaded. Bins leave through an output register, so the last bin may wait
// for m_tready while the next sample is taken. The hop size is written
// through cfg_wr_en/cfg_wr_data (reset 16, zero acts as one).
module stft_frame_analyzer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // sample
    input  logic [0:0]  s_tuser,     // restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,     // frame_number, bin_index, bin_real, bin_imag
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data
);
    import sfa_pkg::*;

    cmd_t    cmd;
    status_t status;

    sfa_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .sample     (s_tdata),
        .restart    (s_tuser[0]),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .status     (status),
        .cmd        (cmd)
    );

    sfa_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );
endmodule

@@ rtl/sfa_checker.sv @@
// port-level assertions for the stft frame analyzer and their bind
module sfa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tlast
);
    import sfa_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    a_last_bin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[21:16] == BIN_W'(NUM_BINS - 1))))
        else $error("tlast does not match final bin");

    a_bin_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !m_tvalid ||
            (m_tdata[21:16] == $past(m_tdata[21:16]) + 1'b1 &&
             m_tdata[15:0] == $past(m_tdata[15:0])))
        else $error("bins of a frame out of order");

    a_no_accept_mid_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken while a frame is in progress");
endmodule

bind stft_frame_analyzer_core sfa_checker u_sfa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);
